// ----- rtl/srp_pkg.sv -----
package srp_pkg;

   // Sheet geometry and cell text size
   localparam int ROWS       = 24;
   localparam int COLUMNS    = 8;
   localparam int CELL_CHARS = 13;

   // Field widths
   localparam int ROW_W  = 5;
   localparam int COL_W  = 3;
   localparam int POS_W  = 4;
   localparam int CHR_W  = 8;
   localparam int RUSE_W = 5;
   localparam int CUSE_W = 4;
   localparam int RSP_DATA_W = 40;

   // Stream operations
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Bytes of interest
   localparam logic [7:0] CH_HOME    = 8'h7A; // 'z'
   localparam logic [7:0] CH_RIGHT   = 8'h64; // 'd'
   localparam logic [7:0] CH_LEFT    = 8'h61; // 'a'
   localparam logic [7:0] CH_DOWN    = 8'h73; // 's'
   localparam logic [7:0] CH_UP      = 8'h77; // 'w'
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CASE_FOLD  = 8'h20;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_TERM    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ROW_W-1:0]    cell_row;
      logic [COL_W-1:0]    cell_column;
      logic [POS_W-1:0]    char_position;
      logic [CHR_W-1:0]    char_value;
      logic                status;
      logic [RUSE_W-1:0]   rows_used;
      logic [CUSE_W-1:0]   columns_used;
      logic [COL_W-1:0]    value_column;
      logic                last;
   } result_type;

endpackage

// ----- rtl/sheet_replay_parser.sv -----
// Channel   Direction  Handshake                    Payload
// req_*     in         req_tvalid / req_tready      tdata: byte_in, tuser: operation
// rsp_*     out        rsp_tvalid / rsp_tready      tdata: cell and summary fields,
//                                                   tuser: result_kind, tlast: last
// csr_*     in         csr_valid / csr_ready        csr_data: value_column_request
//
// One input transfer per cycle. A byte makes at most one result, which is in the
// result register the cycle after the transfer. End of stream inside text makes two
// results (terminator, then summary); the second waits in a pending register and
// holds off req_tready until the terminator has left. Reset is synchronous, active
// high: cursor, capture, extents and output valids clear, value_column_request
// returns to 1. A stalled rsp side holds the result register; req_tready drops while
// the result register is full and rsp_tready is low, or while a result is pending.

module sheet_replay_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] cell_row, [7:5] cell_column,
                                    // [11:8] char_position, [19:12] char_value,
                                    // [20] status, [25:21] rows_used,
                                    // [29:26] columns_used, [32:30] value_column,
                                    // [39:33] zero
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data     // [2:0] value_column_request
);

   // Stream state
   logic [srp_pkg::ROW_W-1:0]  cursor_row_ff,    cursor_row_in;
   logic [srp_pkg::COL_W-1:0]  cursor_column_ff, cursor_column_in;
   logic                       in_text_ff,       in_text_in;
   logic [srp_pkg::POS_W-1:0]  text_position_ff, text_position_in;
   logic                       seen_any_ff,      seen_any_in;
   logic [srp_pkg::RUSE_W-1:0] row_extent_ff,    row_extent_in;
   logic [srp_pkg::CUSE_W-1:0] column_extent_ff, column_extent_in;
   logic [srp_pkg::COL_W-1:0]  vc_request_ff;

   // Output stage: result register plus one pending slot
   srp_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   srp_pkg::result_type pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;

   // Results produced by the current input
   srp_pkg::result_type gen0, gen1;
   logic                gen0_valid, gen1_valid;

   logic                       accept;
   logic                       out_free;
   logic                       op;
   logic [7:0]                 byte_in;
   logic [7:0]                 folded;
   logic                       cell_nonempty;
   logic                       close_seen;
   logic [srp_pkg::RUSE_W-1:0] close_row_ext;
   logic [srp_pkg::CUSE_W-1:0] close_col_ext;
   logic [srp_pkg::RUSE_W-1:0] row_plus;
   logic [srp_pkg::CUSE_W-1:0] col_plus;
   logic [srp_pkg::COL_W-1:0]  vc_resolved;
   srp_pkg::result_type        cell_res;
   srp_pkg::result_type        sum_res;

   assign op       = req_tuser[0];
   assign byte_in  = req_tdata;
   assign folded   = byte_in | srp_pkg::CASE_FOLD;
   assign out_free = !out_valid_ff || rsp_tready;
   assign req_tready = !pend_valid_ff && out_free;
   assign accept   = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Extents as they stand once the open cell (if any) is closed
   assign row_plus      = cursor_row_ff + srp_pkg::RUSE_W'(1);
   assign col_plus      = srp_pkg::CUSE_W'(cursor_column_ff) + srp_pkg::CUSE_W'(1);
   assign cell_nonempty = text_position_ff != '0;
   assign close_seen    = seen_any_ff || (in_text_ff && cell_nonempty);
   assign close_row_ext = (in_text_ff && cell_nonempty && row_plus > row_extent_ff)
                          ? row_plus : row_extent_ff;
   assign close_col_ext = (in_text_ff && cell_nonempty && col_plus > column_extent_ff)
                          ? col_plus : column_extent_ff;

   // Value column clamp against used columns
   always_comb begin
      vc_resolved = vc_request_ff;
      if (close_seen) begin
         if (close_col_ext < srp_pkg::CUSE_W'(2)) begin
            vc_resolved = '0;
         end else if ({1'b0, vc_request_ff} >= close_col_ext) begin
            vc_resolved = srp_pkg::COL_W'(close_col_ext - srp_pkg::CUSE_W'(1));
         end
      end
   end

   always_comb begin
      cell_res               = '0;
      cell_res.kind          = srp_pkg::KIND_TERM;
      cell_res.cell_row      = cursor_row_ff;
      cell_res.cell_column   = cursor_column_ff;
      cell_res.char_position = text_position_ff;
      cell_res.last          = 1'b1;

      sum_res              = '0;
      sum_res.kind         = srp_pkg::KIND_SUMMARY;
      sum_res.status       = !close_seen;
      sum_res.rows_used    = close_row_ext;
      sum_res.columns_used = close_col_ext;
      sum_res.value_column = vc_resolved;
      sum_res.last         = 1'b1;
   end

   // Per-item decode and next state
   always_comb begin
      cursor_row_in    = cursor_row_ff;
      cursor_column_in = cursor_column_ff;
      in_text_in       = in_text_ff;
      text_position_in = text_position_ff;
      seen_any_in      = seen_any_ff;
      row_extent_in    = row_extent_ff;
      column_extent_in = column_extent_ff;
      gen0       = cell_res;
      gen1       = sum_res;
      gen0_valid = 1'b0;
      gen1_valid = 1'b0;

      if (op == srp_pkg::OP_END) begin
         if (in_text_ff) begin
            gen0.last  = 1'b0;
            gen0_valid = 1'b1;
            gen1_valid = 1'b1;
         end else begin
            gen0       = sum_res;
            gen0_valid = 1'b1;
         end
         cursor_row_in    = '0;
         cursor_column_in = '0;
         in_text_in       = 1'b0;
         text_position_in = '0;
         seen_any_in      = 1'b0;
         row_extent_in    = '0;
         column_extent_in = '0;
      end else if (in_text_ff) begin
         if (byte_in == srp_pkg::CH_LF || byte_in == srp_pkg::CH_CR) begin
            gen0_valid       = 1'b1;
            in_text_in       = 1'b0;
            seen_any_in      = close_seen;
            row_extent_in    = close_row_ext;
            column_extent_in = close_col_ext;
         end else if (text_position_ff < srp_pkg::POS_W'(srp_pkg::CELL_CHARS - 1)) begin
            gen0.kind        = srp_pkg::KIND_CHAR;
            gen0.char_value  = byte_in;
            gen0_valid       = 1'b1;
            text_position_in = text_position_ff + srp_pkg::POS_W'(1);
         end
      end else begin
         // cursor moves are case-insensitive
         case (folded)
            srp_pkg::CH_HOME: begin
               cursor_row_in    = '0;
               cursor_column_in = '0;
            end
            srp_pkg::CH_RIGHT: begin
               if (cursor_column_ff != srp_pkg::COL_W'(srp_pkg::COLUMNS - 1))
                  cursor_column_in = cursor_column_ff + srp_pkg::COL_W'(1);
            end
            srp_pkg::CH_LEFT: begin
               if (cursor_column_ff != '0)
                  cursor_column_in = cursor_column_ff - srp_pkg::COL_W'(1);
            end
            srp_pkg::CH_DOWN: begin
               if (cursor_row_ff != srp_pkg::ROW_W'(srp_pkg::ROWS - 1))
                  cursor_row_in = cursor_row_ff + srp_pkg::ROW_W'(1);
            end
            srp_pkg::CH_UP: begin
               if (cursor_row_ff != '0)
                  cursor_row_in = cursor_row_ff - srp_pkg::ROW_W'(1);
            end
            default: begin
            end
         endcase
         if (byte_in == srp_pkg::CH_DQUOTE || byte_in == srp_pkg::CH_SQUOTE ||
             byte_in == srp_pkg::CH_EQUALS || byte_in == srp_pkg::CH_PLUS) begin
            in_text_in       = 1'b1;
            text_position_in = '0;
         end
      end
   end

   // Output stage next state
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (accept && gen0_valid) begin
            out_in        = gen0;
            out_valid_in  = 1'b1;
            pend_in       = gen1;
            pend_valid_in = gen1_valid;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff    <= '0;
         cursor_column_ff <= '0;
         in_text_ff       <= 1'b0;
         text_position_ff <= '0;
         seen_any_ff      <= 1'b0;
         row_extent_ff    <= '0;
         column_extent_ff <= '0;
         vc_request_ff    <= srp_pkg::COL_W'(1);
         out_valid_ff     <= 1'b0;
         pend_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            cursor_row_ff    <= cursor_row_in;
            cursor_column_ff <= cursor_column_in;
            in_text_ff       <= in_text_in;
            text_position_ff <= text_position_in;
            seen_any_ff      <= seen_any_in;
            row_extent_ff    <= row_extent_in;
            column_extent_ff <= column_extent_in;
         end
         if (csr_valid && csr_ready) begin
            vc_request_ff <= csr_data;
         end
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {7'd0,
                        out_ff.value_column,
                        out_ff.columns_used,
                        out_ff.rows_used,
                        out_ff.status,
                        out_ff.char_value,
                        out_ff.char_position,
                        out_ff.cell_column,
                        out_ff.cell_row};

   // pending slot only fills behind a full result register
   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("pending result without a result in the output register");

   // the summary always closes an item's results
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == srp_pkg::KIND_SUMMARY) |-> out_ff.last)
      else $error("end summary without last");

   // end of stream leaves a clean stream state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && op == srp_pkg::OP_END) |=>
         (cursor_row_ff == '0 && cursor_column_ff == '0 && !in_text_ff &&
          !seen_any_ff && row_extent_ff == '0 && column_extent_ff == '0))
      else $error("stream state not cleared after end of stream");

   // the pending slot is only loaded with the summary
   a_pend_summary: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> pend_ff.kind == srp_pkg::KIND_SUMMARY)
      else $error("pending slot holds a cell write");

endmodule
